@@ hdl/fixed_point_vertex_projector_macros.svh @@
// assertion macros for the vertex projector
`ifndef FIXED_POINT_VERTEX_PROJECTOR_MACROS_SVH
`define FIXED_POINT_VERTEX_PROJECTOR_MACROS_SVH
`ifndef SYNTHESIS
`define FVP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FVP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FVP_ASSERT(label, clk, rst_n, prop, msg)
`define FVP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ hdl/fvp_pkg.sv @@
package fvp_pkg;
    localparam int SCREEN_W_DEF = 320;
    localparam int SCREEN_H_DEF = 240;
    localparam int NUM_REGS     = 8;
    localparam int IDX_W        = 3;
    localparam int CFG_W        = 64;
    localparam int DIV_STEPS    = 64;
endpackage

@@ hdl/fvp_divlane.sv @@
// pipelined unsigned restoring divider, one quotient bit per stage
module fvp_divlane (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic [63:0] o_quo
);
    import fvp_pkg::*;
    logic [63:0] r_num [DIV_STEPS];
    logic [63:0] r_rem [DIV_STEPS];
    logic [63:0] r_den [DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_st
        logic [63:0] num_in;
        logic [63:0] rem_in;
        logic [63:0] den_in;
        logic [64:0] n_trial;
        logic [63:0] n_rem;
        logic [63:0] n_num;
        if (s == 0) begin : g_first
            assign num_in = i_num;
            assign rem_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign num_in = r_num[s-1];
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
        end
        always_comb begin
            n_trial = {rem_in, num_in[63]} - {1'b0, den_in};
            n_num   = {num_in[62:0], ~n_trial[64]};
            n_rem   = n_trial[64] ? {rem_in[62:0], num_in[63]} : n_trial[63:0];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s] <= n_num;
                r_rem[s] <= n_rem;
                r_den[s] <= den_in;
            end
        end
    end

    assign o_quo = r_num[DIV_STEPS-1];
endmodule

@@ hdl/fvp_rowsum.sv @@
// four multiply-accumulate rows, products registered before the adder tree
module fvp_rowsum (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    input  logic [31:0] i_z,
    input  logic [63:0] i_regs [fvp_pkg::NUM_REGS],
    output logic [63:0] o_sum [4]
);
    import fvp_pkg::*;
    logic signed [63:0] r_p [4][4];
    logic [63:0] r_s [4][2];

    for (genvar r = 0; r < 4; r++) begin : g_row
        logic signed [31:0] m0, m1, m2, m3;
        assign m0 = i_regs[2*r][31:0];
        assign m1 = i_regs[2*r][63:32];
        assign m2 = i_regs[2*r+1][31:0];
        assign m3 = i_regs[2*r+1][63:32];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[r][0] <= m0 * $signed(i_x);
                r_p[r][1] <= m1 * $signed(i_y);
                r_p[r][2] <= m2 * $signed(i_z);
                r_p[r][3] <= 64'(m3) <<< 10;
                r_s[r][0] <= r_p[r][0] + r_p[r][1];
                r_s[r][1] <= r_p[r][2] + r_p[r][3];
                o_sum[r]  <= r_s[r][0] + r_s[r][1];
            end
        end
    end
endmodule

@@ hdl/fixed_point_vertex_projector.sv @@
// channel | direction | handshake            | word
// input   | in        | i_valid / o_ready    | i_world_x, i_world_y, i_world_z
// output  | out       | o_valid / i_ready    | o_visible, o_screen_x, o_screen_y, o_depth
// config  | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
// one word per cycle unless the pipeline holds; stages in order: row sums, w, divide, mapping
// most of the latency comes from the bit-per-stage dividers for cx, cy, cz
// synchronous active-low reset clears valid bits and matrix registers
// the whole pipeline holds when the output word is not taken; o_ready = !o_valid | i_ready
module fixed_point_vertex_projector #(
    parameter int SCREEN_W = fvp_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = fvp_pkg::SCREEN_H_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [31:0]         i_world_x,
    input  logic signed [31:0]         i_world_y,
    input  logic signed [31:0]         i_world_z,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_visible,
    output logic signed [15:0]         o_screen_x,
    output logic signed [15:0]         o_screen_y,
    output logic [10:0]                o_depth,
    input  logic                       i_cfg_we,
    input  logic [fvp_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [fvp_pkg::CFG_W-1:0]  i_cfg_data
);
    import fvp_pkg::*;
    `include "fixed_point_vertex_projector_macros.svh"

    localparam int LAT = 3 + 1 + DIV_STEPS + 3;

    logic [63:0] r_regs [NUM_REGS];
    logic        en;
    logic [LAT-1:0] r_vld;
    logic [63:0] sum [4];

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) r_regs[k] <= '0;
        end else if (i_cfg_we) begin
            r_regs[i_cfg_idx] <= i_cfg_data;
        end
    end

    fvp_rowsum u_rows (
        .i_clk(i_clk), .i_en(en), .i_x(i_world_x), .i_y(i_world_y), .i_z(i_world_z),
        .i_regs(r_regs), .o_sum(sum)
    );

    // w stage: w = sum3 / 1024, w is flagged ok only when positive, make magnitudes
    logic signed [63:0] s3;
    logic [63:0] n_w;
    logic [63:0] r_w, r_a [3];
    logic [2:0]  r_neg;
    logic        r_wok;
    assign s3  = sum[3];
    assign n_w = 64'(s3 >>> 10);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w   <= n_w;
            r_wok <= !s3[63] && (s3[62:10] != 53'd0);
            for (int k = 0; k < 3; k++) begin
                r_neg[k] <= sum[k][63];
                r_a[k]   <= sum[k][63] ? -sum[k] : sum[k];
            end
        end
    end

    // side bits: sign and w-ok travel alongside the divider
    logic [3:0] r_side [DIV_STEPS];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= {r_wok, r_neg};
            for (int k = 1; k < DIV_STEPS; k++) r_side[k] <= r_side[k-1];
        end
    end

    logic [63:0] q [3];
    for (genvar k = 0; k < 3; k++) begin : g_div
        fvp_divlane u_div (
            .i_clk(i_clk), .i_en(en), .i_num(r_a[k]),
            .i_den(r_wok ? r_w : 64'd1), .o_quo(q[k])
        );
    end

    // sign, depth check and clamp
    logic signed [64:0] c [3];
    logic signed [41:0] cxl, cyl;
    logic        vis;
    always_comb begin
        for (int k = 0; k < 3; k++)
            c[k] = r_side[DIV_STEPS-1][k] ? -$signed({1'b0, q[k]}) : $signed({1'b0, q[k]});
        vis = r_side[DIV_STEPS-1][3] && (c[2] > 0) && (c[2] <= 65'sd1024);
        cxl = (c[0] > 65'sd1099511627776) ? 42'sd1099511627776 :
              (c[0] < -65'sd1099511627776) ? -42'sd1099511627776 : 42'(c[0]);
        cyl = (c[1] > 65'sd1099511627776) ? 42'sd1099511627776 :
              (c[1] < -65'sd1099511627776) ? -42'sd1099511627776 : 42'(c[1]);
    end

    logic signed [41:0] r_cx, r_cy;
    logic               r_vis0;
    logic [10:0]        r_dep0;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx   <= cxl;
            r_cy   <= cyl;
            r_vis0 <= vis;
            r_dep0 <= c[2][10:0];
        end
    end

    // screen scaling
    logic signed [63:0] r_tx, r_ty;
    logic               r_vis1;
    logic [10:0]        r_dep1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tx   <= (64'(r_cx) + 64'sd1024) * 64'(SCREEN_W - 1);
            r_ty   <= (64'(r_cy) + 64'sd1024) * 64'(SCREEN_H - 1);
            r_vis1 <= r_vis0;
            r_dep1 <= r_dep0;
        end
    end

    logic signed [63:0] sx, sy;
    always_comb begin
        // truncate toward zero for /2048
        sx = (r_tx < 0) ? -((-r_tx) >>> 11) : (r_tx >>> 11);
        sy = 64'(SCREEN_H) - ((r_ty < 0) ? -((-r_ty) >>> 11) : (r_ty >>> 11));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_visible  <= r_vis1;
            o_screen_x <= !r_vis1 ? 16'sd0 : (sx > 32767) ? 16'sh7fff :
                          (sx < -32768) ? 16'sh8000 : sx[15:0];
            o_screen_y <= !r_vis1 ? 16'sd0 : (sy > 32767) ? 16'sh7fff :
                          (sy < -32768) ? 16'sh8000 : sy[15:0];
            o_depth    <= r_vis1 ? r_dep1 : 11'd0;
        end
    end

    `FVP_ASSERT(a_stall_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> $stable(r_vld), "stall moved")
    `FVP_ASSERT(a_depth_vis, i_clk, i_rst_n, (o_valid && !o_visible) |-> (o_depth == 11'd0), "depth set")
    `FVP_ASSERT(a_depth_rng, i_clk, i_rst_n, (o_valid && o_visible) |-> (o_depth != 11'd0 && o_depth <= 11'd1024), "depth range")
    `FVP_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !o_valid, "valid after reset")
endmodule
